// File: design/sqa_pkg.sv
// Shared constants, types and helpers of the sorted sleep queue alarm block.
// Used by the interfaces, the controller and the top level.
`default_nettype none

package sqa_pkg;

    // Queue geometry and field widths
    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int DELAY_W     = 31;
    localparam int NOW_W       = 32;
    localparam int SUM_W       = ((TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W) + 1;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [PTR_W-1:0]     ptr_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [ID_W-1:0]      id_t;

    // One queue entry as held in the RAM
    typedef struct packed {
        time_t wake;
        id_t   id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        KIND_WOKEN  = 2'd0,
        KIND_ACTION = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_FULL   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_YIELD   = 2'd1,
        ACT_DISABLE = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_PLACE,
        ST_REPLY,
        ST_SCAN,
        ST_ACTION
    } state_t;

    typedef enum logic {
        OP_SLEEP = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    // Physical slot of a logical queue position: head plus offset, modulo the depth
    function automatic ptr_t wrap_addr(input ptr_t head, input ptr_t offset);
        logic [PTR_W:0] sum;
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= (PTR_W + 1)'(QUEUE_DEPTH))
            sum = sum - (PTR_W + 1)'(QUEUE_DEPTH);
        return sum[PTR_W-1:0];
    endfunction

    // Wake time: now plus delay, clamped at the counter maximum
    function automatic time_t sat_wake(input logic [NOW_W-1:0] now_ticks,
                                       input logic [DELAY_W-1:0] delay);
        logic [SUM_W-1:0] sum;
        time_t            now_t;
        now_t = TIME_BITS'(now_ticks);
        sum   = SUM_W'(now_t) + SUM_W'(delay);
        if (sum[SUM_W-1:TIME_BITS] != '0)
            return '1;
        return sum[TIME_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/sqa_req_if.sv
// Request channel of the sleep queue: valid/ready handshake with one request word.
// Depends on sqa_pkg for the field widths.
`default_nettype none

interface sqa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [sqa_pkg::ID_W-1:0]      thread_id;
    logic [sqa_pkg::DELAY_W-1:0]   delay;
    logic [sqa_pkg::NOW_W-1:0]     now_ticks;
    logic                          idle_mode;
    logic                          future_pending;

    modport source (
        output valid, operation, thread_id, delay, now_ticks, idle_mode, future_pending,
        input  ready
    );

    modport sink (
        input  valid, operation, thread_id, delay, now_ticks, idle_mode, future_pending,
        output ready
    );
endinterface

`default_nettype wire

// File: design/sqa_rsp_if.sv
// Result channel of the sleep queue: valid/ready handshake with one result word.
// Depends on sqa_pkg for the field widths.
`default_nettype none

interface sqa_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic [sqa_pkg::ID_W-1:0] woken_id;
    logic [1:0]               action;
    logic                     last;

    modport source (
        output valid, kind, woken_id, action, last,
        input  ready
    );

    modport sink (
        input  valid, kind, woken_id, action, last,
        output ready
    );
endinterface

`default_nettype wire

// File: design/sqa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; the sleep queue instantiates it for its entries.
`default_nettype none

module sqa_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 40,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/sqa_ctrl.sv
// Sequencer of the sleep queue: sorted insert, release scan and the result register.
// Depends on sqa_pkg, the request/result interfaces and an external entry RAM.
`default_nettype none

module sqa_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    sqa_req_if.sink               req,
    sqa_rsp_if.source             rsp,
    output logic                  ram_we,
    output sqa_pkg::ptr_t         ram_waddr,
    output sqa_pkg::entry_t       ram_wdata,
    output sqa_pkg::ptr_t         ram_raddr,
    input  wire sqa_pkg::entry_t  ram_rdata
);

    sqa_pkg::state_t  state_reg, state_next;
    sqa_pkg::ptr_t    head_reg, head_next;
    sqa_pkg::cnt_t    count_reg, count_next;
    sqa_pkg::ptr_t    idx_reg, idx_next;
    sqa_pkg::time_t   wake_reg, wake_next;
    sqa_pkg::time_t   now_reg, now_next;
    sqa_pkg::id_t     id_reg, id_next;
    logic             idle_reg, idle_next;
    logic             future_reg, future_next;
    logic             woke_reg, woke_next;
    sqa_pkg::kind_t   reply_kind_reg, reply_kind_next;

    logic             out_valid_reg, out_valid_next;
    sqa_pkg::kind_t   out_kind_reg, out_kind_next;
    sqa_pkg::id_t     out_id_reg, out_id_next;
    sqa_pkg::action_t out_action_reg, out_action_next;
    logic             out_last_reg, out_last_next;

    logic             accept;
    logic             out_free;
    logic             is_full;
    logic             is_empty;
    logic             shift_up;
    logic             due;
    logic             pop;
    sqa_pkg::entry_t  new_entry;
    sqa_pkg::action_t tick_action;

    // Handshake and shared conditions
    assign req.ready = (state_reg == sqa_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign is_full   = (count_reg == sqa_pkg::CNT_W'(sqa_pkg::QUEUE_DEPTH));
    assign is_empty  = (count_reg == '0);
    assign shift_up  = (ram_rdata.wake > wake_reg);
    assign due       = (ram_rdata.wake <= now_reg);
    assign pop       = (state_reg == sqa_pkg::ST_SCAN) && due && out_free;
    assign new_entry = '{wake: wake_reg, id: id_reg};

    // Tick action from the state left after the release
    always_comb
    begin
        if (idle_reg && !woke_reg && is_empty)
            tick_action = future_reg ? sqa_pkg::ACT_NONE : sqa_pkg::ACT_DISABLE;
        else
            tick_action = sqa_pkg::ACT_YIELD;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sqa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (sqa_pkg::op_t'(req.operation) == sqa_pkg::OP_TICK)
                        state_next = is_empty ? sqa_pkg::ST_ACTION : sqa_pkg::ST_SCAN;
                    else if (is_full)
                        state_next = sqa_pkg::ST_REPLY;
                    else if (is_empty)
                        state_next = sqa_pkg::ST_PLACE;
                    else
                        state_next = sqa_pkg::ST_INSERT;
                end
            end
            sqa_pkg::ST_INSERT:
            begin
                if (!shift_up)
                    state_next = sqa_pkg::ST_REPLY;
                else if (idx_reg == '0)
                    state_next = sqa_pkg::ST_PLACE;
            end
            sqa_pkg::ST_PLACE:
                state_next = sqa_pkg::ST_REPLY;
            sqa_pkg::ST_REPLY:
            begin
                if (out_free)
                    state_next = sqa_pkg::ST_IDLE;
            end
            sqa_pkg::ST_SCAN:
            begin
                if (!due)
                    state_next = sqa_pkg::ST_ACTION;
                else if (pop && count_reg == sqa_pkg::CNT_W'(1))
                    state_next = sqa_pkg::ST_ACTION;
            end
            sqa_pkg::ST_ACTION:
            begin
                if (out_free)
                    state_next = sqa_pkg::ST_IDLE;
            end
            default:
                state_next = sqa_pkg::ST_IDLE;
        endcase
    end

    // Datapath, RAM accesses and result loading
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        wake_next       = wake_reg;
        now_next        = now_reg;
        id_next         = id_reg;
        idle_next       = idle_reg;
        future_next     = future_reg;
        woke_next       = woke_reg;
        reply_kind_next = reply_kind_reg;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_action_next = out_action_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        ram_we          = 1'b0;
        ram_waddr       = sqa_pkg::wrap_addr(head_reg, idx_reg + sqa_pkg::PTR_W'(1));
        ram_wdata       = new_entry;
        ram_raddr       = head_reg;

        case (state_reg)
            sqa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    // Latch the request word
                    wake_next   = sqa_pkg::sat_wake(req.now_ticks, req.delay);
                    now_next    = sqa_pkg::TIME_BITS'(req.now_ticks);
                    id_next     = req.thread_id;
                    idle_next   = req.idle_mode;
                    future_next = req.future_pending;
                    woke_next   = 1'b0;
                    idx_next    = sqa_pkg::PTR_W'(count_reg - sqa_pkg::CNT_W'(1));
                    if (is_empty)
                        idx_next = '0;
                    reply_kind_next = is_full ? sqa_pkg::KIND_FULL : sqa_pkg::KIND_ACCEPT;
                    // Start the walk at the tail for a sleep, at the head for a tick
                    if (sqa_pkg::op_t'(req.operation) == sqa_pkg::OP_SLEEP)
                        ram_raddr = sqa_pkg::wrap_addr(head_reg,
                                        sqa_pkg::PTR_W'(count_reg - sqa_pkg::CNT_W'(1)));
                end
            end
            sqa_pkg::ST_INSERT:
            begin
                // Move a later entry up one slot, or drop the new one in behind it
                ram_we = 1'b1;
                if (shift_up)
                begin
                    ram_wdata = ram_rdata;
                    if (idx_reg != '0)
                    begin
                        idx_next  = idx_reg - sqa_pkg::PTR_W'(1);
                        ram_raddr = sqa_pkg::wrap_addr(head_reg,
                                                       idx_reg - sqa_pkg::PTR_W'(1));
                    end
                end
                else
                begin
                    count_next = count_reg + sqa_pkg::CNT_W'(1);
                end
            end
            sqa_pkg::ST_PLACE:
            begin
                // Write the new entry at the front of the walked range
                ram_we     = 1'b1;
                ram_waddr  = sqa_pkg::wrap_addr(head_reg, idx_reg);
                count_next = count_reg + sqa_pkg::CNT_W'(1);
            end
            sqa_pkg::ST_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = reply_kind_reg;
                    out_id_next     = id_reg;
                    out_action_next = sqa_pkg::ACT_NONE;
                    out_last_next   = 1'b1;
                end
            end
            sqa_pkg::ST_SCAN:
            begin
                // Release the head entry while due; reread it while the result is held
                if (pop)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = sqa_pkg::KIND_WOKEN;
                    out_id_next     = ram_rdata.id;
                    out_action_next = sqa_pkg::ACT_NONE;
                    out_last_next   = 1'b0;
                    head_next       = sqa_pkg::wrap_addr(head_reg, sqa_pkg::PTR_W'(1));
                    count_next      = count_reg - sqa_pkg::CNT_W'(1);
                    woke_next       = 1'b1;
                    ram_raddr       = sqa_pkg::wrap_addr(head_reg, sqa_pkg::PTR_W'(1));
                end
            end
            sqa_pkg::ST_ACTION:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = sqa_pkg::KIND_ACTION;
                    out_id_next     = '0;
                    out_action_next = tick_action;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sqa_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        wake_reg       <= wake_next;
        now_reg        <= now_next;
        id_reg         <= id_next;
        idle_reg       <= idle_next;
        future_reg     <= future_next;
        woke_reg       <= woke_next;
        reply_kind_reg <= reply_kind_next;
        out_kind_reg   <= out_kind_next;
        out_id_reg     <= out_id_next;
        out_action_reg <= out_action_next;
        out_last_reg   <= out_last_next;
    end

    // Result word
    assign rsp.valid    = out_valid_reg;
    assign rsp.kind     = out_kind_reg;
    assign rsp.woken_id = out_id_reg;
    assign rsp.action   = out_action_reg;
    assign rsp.last     = out_last_reg;

endmodule

`default_nettype wire

// File: design/sorted_sleep_queue_alarm_core.sv
// Top level of the sorted sleep queue alarm: controller plus entry RAM.
// Depends on sqa_pkg, sqa_req_if, sqa_rsp_if, sqa_ram and sqa_ctrl.
//
// Sleeping threads are kept in wake-time order in a circular buffer held in one
// RAM with a registered read, indexed from a head pointer. A sleep request walks
// back from the tail, reading one entry and writing it one slot up each cycle
// while that entry's wake time is later than the new one, and ends with the
// write of the new entry; a rejected request goes straight to its reply. A tick
// releases due threads from the head, popping the head and reading the next head
// through the same read port in the same cycle, and when any entry stays queued
// stops at the first entry that is not yet due. Results go out through a
// registered output word; a stalled result holds the sequencer at that step.
// The RAM needs no clearing after reset.
`default_nettype none

module sorted_sleep_queue_alarm_core (
    input  wire logic clk,
    input  wire logic rst_n,
    sqa_req_if.sink   req,
    sqa_rsp_if.source rsp
);

    logic            ram_we;
    sqa_pkg::ptr_t   ram_waddr;
    sqa_pkg::entry_t ram_wdata;
    sqa_pkg::ptr_t   ram_raddr;
    sqa_pkg::entry_t ram_rdata;

    // Sequencer
    sqa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Entry store: wake time and thread id per slot
    sqa_ram #(
        .DEPTH  (sqa_pkg::QUEUE_DEPTH),
        .WIDTH  (sqa_pkg::ENTRY_W),
        .ADDR_W (sqa_pkg::PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire
